### hdl/lcdns_pkg.sv
`timescale 1ns / 1ps

package lcdns_pkg;

    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_CMD  = 2'd1;
    localparam logic [1:0] REQ_NIB  = 2'd2;

    localparam logic [2:0] CFG_LINE_TWO_START    = 3'd0;
    localparam logic [2:0] CFG_LINE_ONE_BASE_CMD = 3'd1;
    localparam logic [2:0] CFG_LINE_TWO_BASE_CMD = 3'd2;
    localparam logic [2:0] CFG_ENABLE_HOLD_US    = 3'd3;
    localparam logic [2:0] CFG_COMMAND_EXTRA_US  = 3'd4;

    localparam logic [7:0] RST_LINE_TWO_START    = 8'd16;
    localparam logic [7:0] RST_LINE_ONE_BASE_CMD = 8'd128;
    localparam logic [7:0] RST_LINE_TWO_BASE_CMD = 8'd192;
    localparam logic [7:0] RST_ENABLE_HOLD_US    = 8'd20;
    localparam logic [7:0] RST_COMMAND_EXTRA_US  = 8'd40;

    localparam logic [7:0] POS_UNKNOWN  = 8'hFF;
    localparam logic [7:0] SETUP_HOLD_US = 8'd1;
    localparam logic [7:0] HOLD_MAX      = 8'hFF;

    typedef struct packed {
        logic [7:0] line_two_start;
        logic [7:0] line_one_base_cmd;
        logic [7:0] line_two_base_cmd;
        logic [7:0] enable_hold_us;
        logic [7:0] command_extra_us;
    } t_cfg;

    // up to four nibbles, sent from index 0 to last_idx
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0]      rs;
        logic [3:0][3:0] nib;
    } t_desc;

endpackage

### hdl/lcdns_if.sv
`timescale 1ns / 1ps

interface lcdns_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] position;
    logic [7:0] char_value;

    modport source (output valid, req_type, position, char_value, input ready);
    modport sink   (input valid, req_type, position, char_value, output ready);
endinterface

interface lcdns_seg_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       enable_pin;
    logic [3:0] bus_nibble;
    logic [7:0] hold_us;
    logic       last_segment;

    modport source (output valid, reg_select, enable_pin, bus_nibble, hold_us, last_segment,
                    input ready);
    modport sink   (input valid, reg_select, enable_pin, bus_nibble, hold_us, last_segment,
                    output ready);
endinterface

### hdl/char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
// channel   direction  fields
// i_req     in         req_type[1:0], position[7:0], char_value[7:0]
// o_seg     out        reg_select, enable_pin, bus_nibble[3:0], hold_us[7:0], last_segment
// i_cfg_*   in         write enable, index[2:0], data[7:0]
//
// one pin segment leaves per cycle while o_seg is ready; a character with set-address
// is 16 segments, a character or command byte 8, a command nibble 4, a reserved type none
// the segment sequencer sets the rate; the request queue lets the front keep taking
// transfers while it works, so items follow back to back
// synchronous reset clears position tracking, driven nibble, queue and the
// registers to their defaults
// a stall on o_seg holds the output register and fills the queue, then drops i_req.ready

module char_lcd_nibble_write_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdns_req_if.sink   i_req,
    lcdns_seg_if.source o_seg,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import lcdns_pkg::*;

    t_cfg  r_cfg;
    t_desc desc;
    t_desc head;
    logic  push;
    logic  full;
    logic  pop;
    logic  head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_two_start    <= RST_LINE_TWO_START;
            r_cfg.line_one_base_cmd <= RST_LINE_ONE_BASE_CMD;
            r_cfg.line_two_base_cmd <= RST_LINE_TWO_BASE_CMD;
            r_cfg.enable_hold_us    <= RST_ENABLE_HOLD_US;
            r_cfg.command_extra_us  <= RST_COMMAND_EXTRA_US;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_TWO_START:    r_cfg.line_two_start    <= i_cfg_data;
                CFG_LINE_ONE_BASE_CMD: r_cfg.line_one_base_cmd <= i_cfg_data;
                CFG_LINE_TWO_BASE_CMD: r_cfg.line_two_base_cmd <= i_cfg_data;
                CFG_ENABLE_HOLD_US:    r_cfg.enable_hold_us    <= i_cfg_data;
                CFG_COMMAND_EXTRA_US:  r_cfg.command_extra_us  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lcdns_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_desc  (desc)
    );

    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    lcdns_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_seg        (o_seg)
    );

endmodule

### hdl/lcdns_queue.sv
`timescale 1ns / 1ps

module lcdns_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcdns_pkg::t_desc i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lcdns_pkg::t_desc o_head
);
    import lcdns_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] p);
        f_wrap = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_wrap(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_wrap(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

### hdl/lcdns_front.sv
`timescale 1ns / 1ps

module lcdns_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lcdns_req_if.sink        i_req,
    input  lcdns_pkg::t_cfg  i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output lcdns_pkg::t_desc o_desc
);
    import lcdns_pkg::*;

    logic [7:0] r_expected;
    logic       accept;
    logic [7:0] addr_cmd;
    logic [7:0] val;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;
    assign val         = i_req.char_value;

    always_comb begin
        if (i_req.position < i_cfg.line_two_start) begin
            addr_cmd = i_cfg.line_one_base_cmd + i_req.position;
        end else begin
            addr_cmd = i_cfg.line_two_base_cmd + i_req.position - i_cfg.line_two_start;
        end
    end

    always_comb begin
        o_desc = '0;
        o_push = accept;
        case (i_req.req_type)
            REQ_CHAR: begin
                if (r_expected != i_req.position) begin
                    o_desc.last_idx = 2'd3;
                    o_desc.rs       = 4'b1100;
                    o_desc.nib      = {val[3:0], val[7:4], addr_cmd[3:0], addr_cmd[7:4]};
                end else begin
                    o_desc.last_idx = 2'd1;
                    o_desc.rs       = 4'b0011;
                    o_desc.nib      = {8'h00, val[3:0], val[7:4]};
                end
            end
            REQ_CMD: begin
                o_desc.last_idx = 2'd1;
                o_desc.nib      = {8'h00, val[3:0], val[7:4]};
            end
            REQ_NIB: begin
                o_desc.last_idx = 2'd0;
                o_desc.nib      = {12'h000, val[3:0]};
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= POS_UNKNOWN;
        end else if (accept && i_req.req_type == REQ_CHAR) begin
            r_expected <= i_req.position + 8'd1;
        end
    end

endmodule

### hdl/lcdns_back.sv
`timescale 1ns / 1ps

module lcdns_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lcdns_pkg::t_cfg  i_cfg,
    input  logic             i_head_valid,
    input  lcdns_pkg::t_desc i_head,
    output logic             o_pop,
    lcdns_seg_if.source      o_seg
);
    import lcdns_pkg::*;

    typedef enum logic [3:0] {
        SEG_SETUP = 4'b0001,
        SEG_EN_HI = 4'b0010,
        SEG_DATA  = 4'b0100,
        SEG_EN_LO = 4'b1000
    } t_seg;

    t_seg       r_seg;
    logic [1:0] r_nib;
    logic [3:0] r_driven;
    logic       r_out_valid;
    logic       r_out_rs;
    logic       r_out_en;
    logic [3:0] r_out_bus;
    logic [7:0] r_out_hold;
    logic       r_out_last;

    logic       advance;
    logic       last;
    logic [3:0] cur_nib;
    logic       cur_rs;
    logic [8:0] tail_sum;
    logic [7:0] tail_hold;
    t_seg       n_seg;
    logic       n_en;
    logic [3:0] n_bus;
    logic [7:0] n_hold;

    assign cur_nib   = i_head.nib[r_nib];
    assign cur_rs    = i_head.rs[r_nib];
    assign advance   = i_head_valid && (!r_out_valid || o_seg.ready);
    assign last      = (r_seg == SEG_EN_LO) && (r_nib == i_head.last_idx);
    assign o_pop     = advance && last;
    assign tail_sum  = {1'b0, i_cfg.enable_hold_us}
                     + {1'b0, (cur_rs ? 8'd0 : i_cfg.command_extra_us)};
    assign tail_hold = tail_sum[8] ? HOLD_MAX : tail_sum[7:0];

    always_comb begin
        case (r_seg)
            SEG_SETUP: begin
                n_seg = SEG_EN_HI;
                n_en = 1'b0; n_bus = r_driven; n_hold = SETUP_HOLD_US;
            end
            SEG_EN_HI: begin
                n_seg = SEG_DATA;
                n_en = 1'b1; n_bus = r_driven; n_hold = SETUP_HOLD_US;
            end
            SEG_DATA: begin
                n_seg = SEG_EN_LO;
                n_en = 1'b1; n_bus = cur_nib; n_hold = i_cfg.enable_hold_us;
            end
            default: begin
                n_seg = SEG_SETUP;
                n_en = 1'b0; n_bus = cur_nib; n_hold = tail_hold;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rs   <= cur_rs;
            r_out_en   <= n_en;
            r_out_bus  <= n_bus;
            r_out_hold <= n_hold;
            r_out_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_seg       <= SEG_SETUP;
            r_nib       <= '0;
            r_driven    <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_seg       <= n_seg;
            if (r_seg == SEG_EN_LO) begin
                r_nib <= last ? 2'd0 : r_nib + 2'd1;
            end
            if (r_seg == SEG_DATA) begin
                r_driven <= cur_nib;
            end
        end else if (o_seg.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_seg.valid        = r_out_valid;
    assign o_seg.reg_select   = r_out_rs;
    assign o_seg.enable_pin   = r_out_en;
    assign o_seg.bus_nibble   = r_out_bus;
    assign o_seg.hold_us      = r_out_hold;
    assign o_seg.last_segment = r_out_last;

    a_last_en_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_out_en)
        else $error("final segment with enable high");

    a_pop_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_seg == SEG_SETUP && r_nib == 2'd0))
        else $error("sequencer not back at first segment after pop");

    a_nib_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_nib <= i_head.last_idx))
        else $error("nibble index past descriptor end");

endmodule
